FILE: hw/rtl/matrix_vector_multiply_top_macros.svh
// Assertion helpers used by the block's datapath RTL.
// Each expects clk_i and rst_ni in scope.
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication.
`define MVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MVM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mvm_pkg.sv
package mvm_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_LOAD_VEC = 2'd1,
    OP_COMPUTE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_mat;
    logic load_vec;
    logic start;     // row 0, column 0, clear accumulator
    logic issue;     // read one element pair, advance column
    logic next_row;  // advance row, column 0, clear accumulator
    logic emit;      // load the output register with the row sum
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic no_rows;
    logic col_end;
    logic col_last;
    logic last_row;
    logic busy;
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/mvm_ctrl.sv
module mvm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mvm_pkg::OP_W-1:0]      op_i,
  input  mvm_pkg::stat_t                stat_i,
  output logic                          in_ready_o,
  output mvm_pkg::cmd_t                 cmd_o
);

  mvm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mvm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (mvm_pkg::op_e'(op_i))
            mvm_pkg::OP_LOAD_MAT: begin
              cmd_o.load_mat = 1'b1;
            end
            mvm_pkg::OP_LOAD_VEC: begin
              cmd_o.load_vec = 1'b1;
            end
            mvm_pkg::OP_COMPUTE: begin
              cmd_o.start = 1'b1;
              state_d     = stat_i.no_rows ? mvm_pkg::ST_IDLE : mvm_pkg::ST_ISSUE;
            end
            default: begin
              // unused opcode: word taken, nothing done
            end
          endcase
        end
      end
      mvm_pkg::ST_ISSUE: begin
        if (stat_i.col_end) begin
          state_d = mvm_pkg::ST_DRAIN;  // no columns in use
        end else begin
          cmd_o.issue = 1'b1;
          if (stat_i.col_last) begin
            state_d = mvm_pkg::ST_DRAIN;
          end
        end
      end
      mvm_pkg::ST_DRAIN: begin
        if (!stat_i.busy && stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.next_row = 1'b1;
          state_d = stat_i.last_row ? mvm_pkg::ST_IDLE : mvm_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_d = mvm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mvm_datapath.sv
`include "matrix_vector_multiply_top_macros.svh"

module mvm_datapath #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mvm_pkg::cmd_t                        cmd_i,
  output mvm_pkg::stat_t                       stat_o,
  input  logic [mvm_pkg::IDX_W-1:0]            row_index_i,
  input  logic [mvm_pkg::IDX_W-1:0]            col_index_i,
  input  logic signed [mvm_pkg::DATA_W-1:0]    value_i,
  input  logic                                 cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mvm_pkg::CNT_W-1:0]            cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mvm_pkg::IDX_W-1:0]            result_row_o,
  output logic signed [mvm_pkg::DATA_W-1:0]    result_value_o,
  output logic                                 last_o
);

  localparam int unsigned RCW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RSAT_W = (RCW > mvm_pkg::CNT_W) ? RCW : mvm_pkg::CNT_W;
  localparam int unsigned CSAT_W = (CCW > mvm_pkg::CNT_W) ? CCW : mvm_pkg::CNT_W;
  localparam int unsigned ROUT_W = (RCW > mvm_pkg::IDX_W) ? RCW : mvm_pkg::IDX_W;
  localparam int unsigned DW     = mvm_pkg::DATA_W;
  localparam int unsigned AccW   = mvm_pkg::ACC_W;

  // configuration
  logic [mvm_pkg::CNT_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= mvm_pkg::CNT_RESET;
      cols_q <= mvm_pkg::CNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mvm_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        mvm_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // counts clamped to the store size
  logic [RSAT_W-1:0] rows_ext;
  logic [CSAT_W-1:0] cols_ext;
  logic [RCW-1:0]    nr;
  logic [CCW-1:0]    nc;

  assign rows_ext = RSAT_W'(rows_q);
  assign cols_ext = CSAT_W'(cols_q);
  assign nr = RCW'((rows_ext > RSAT_W'(MAX_ROWS)) ? RSAT_W'(MAX_ROWS) : rows_ext);
  assign nc = CCW'((cols_ext > CSAT_W'(MAX_COLS)) ? CSAT_W'(MAX_COLS) : cols_ext);

  // row / column walk
  logic [RCW-1:0] row_q;
  logic [CCW-1:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.start) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.next_row) begin
      row_q <= row_q + RCW'(1);
      col_q <= '0;
    end else if (cmd_i.issue) begin
      col_q <= col_q + CCW'(1);
    end
  end

  // stores
  logic [DW-1:0]  mat_mem [DEPTH];
  logic [DW-1:0]  vec_mem [MAX_COLS];
  logic           mat_we, vec_we;
  logic [AW-1:0]  mat_wr_addr, mat_rd_addr;
  logic [CIW-1:0] vec_wr_addr, vec_rd_addr;
  logic [DW-1:0]  mat_rd_q, vec_rd_q;

  assign mat_we = cmd_i.load_mat && (32'(row_index_i) < MAX_ROWS)
                  && (32'(col_index_i) < MAX_COLS);
  assign vec_we = cmd_i.load_vec && (32'(col_index_i) < MAX_COLS);
  assign mat_wr_addr = AW'(32'(row_index_i) * MAX_COLS + 32'(col_index_i));
  assign mat_rd_addr = AW'(32'(row_q[RIW-1:0]) * MAX_COLS + 32'(col_q[CIW-1:0]));
  assign vec_wr_addr = CIW'(col_index_i);
  assign vec_rd_addr = col_q[CIW-1:0];

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_wr_addr] <= value_i;
    end
    if (cmd_i.issue) begin
      mat_rd_q <= mat_mem[mat_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_wr_addr] <= value_i;
    end
    if (cmd_i.issue) begin
      vec_rd_q <= vec_mem[vec_rd_addr];
    end
  end

  // multiply, then accumulate
  logic                                rd_v_q, mul_v_q;
  logic signed [mvm_pkg::PROD_W-1:0]   prod_q;
  logic [AccW-1:0]                     acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.issue;
      mul_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= $signed(mat_rd_q) * $signed(vec_rd_q);
    end
  end

  // product >> 16 is exactly bits 63:16; the add wraps at 48 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.start || cmd_i.next_row) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + prod_q[mvm_pkg::PROD_W-1:mvm_pkg::FRAC_W];
    end
  end

  // saturate to 32 bits
  logic [DW-1:0]      sat_val;
  logic [AccW-DW:0]   acc_hi;

  assign acc_hi = acc_q[AccW-1:DW-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat_val = acc_q[DW-1:0];
    end else if (acc_q[AccW-1]) begin
      sat_val = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DW-1){1'b1}}};
    end
  end

  // output register
  logic                       out_valid_q;
  logic [mvm_pkg::IDX_W-1:0]  out_row_q;
  logic [DW-1:0]              out_val_q;
  logic                       out_last_q;
  logic [ROUT_W-1:0]          row_ext;

  assign row_ext = ROUT_W'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q  <= row_ext[mvm_pkg::IDX_W-1:0];
      out_val_q  <= sat_val;
      out_last_q <= stat_o.last_row;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_row_o   = out_row_q;
  assign result_value_o = out_val_q;
  assign last_o         = out_last_q;

  // status
  assign stat_o.no_rows  = (nr == '0);
  assign stat_o.col_end  = (col_q == nc);
  assign stat_o.col_last = ((col_q + CCW'(1)) == nc);
  assign stat_o.last_row = ((row_q + RCW'(1)) == nr);
  assign stat_o.busy     = rd_v_q || mul_v_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  `MVM_ASSERT_IMP(a_clr_not_mid_row, cmd_i.start || cmd_i.next_row, !mul_v_q,
                  "accumulator cleared while a product is in flight")
  `MVM_ASSERT_IMP(a_emit_drained, cmd_i.emit, !rd_v_q && !mul_v_q,
                  "row sum emitted before the pipeline drained")
  `MVM_ASSERT_IMP(a_emit_no_overwrite, cmd_i.emit, !out_valid_q || out_ready_i,
                  "output word overwritten before it was taken")
  `MVM_ASSERT_NXT(a_issue_in_range, cmd_i.issue, col_q <= nc,
                  "column walk ran past the columns in use")

endmodule

FILE: hw/rtl/matrix_vector_multiply_top.sv
// Dense matrix-vector product, signed Q16.16.
// Input channel (in_valid_i / in_ready_o): each word carries op_i, row_index_i,
// col_index_i and value_i. op LOAD_MAT writes matrix[row][col], LOAD_VEC writes
// vector[col], COMPUTE walks the rows in use and sends one output word per row,
// in row order, last_o set on the final row. Any other op is taken and dropped.
// Output channel (out_valid_o / out_ready_i): result_row_o, result_value_o
// (48-bit row sum saturated to 32 bits), last_o.
// Config port: cfg_we_i / cfg_idx_i / cfg_data_i, index 0 rows in use, index 1
// columns in use; write only while the block is idle.
// Compute: one multiply-accumulate per cycle within a row, on a single 32x32
// multiplier fed by the matrix and vector memories; each row then drains its
// read, multiply and accumulate registers before the row sum is emitted. With
// no columns in use a row still passes the issue and drain states and emits 0.
// The output register frees the input side: loads are taken while a result
// waits. If the receiver stalls, the walk holds at the end of the next row.
// Reset clears control state and sets both counts to 16; stores are undefined
// until written.
module matrix_vector_multiply_top #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mvm_pkg::OP_W-1:0]             op_i,
  input  logic [mvm_pkg::IDX_W-1:0]            row_index_i,
  input  logic [mvm_pkg::IDX_W-1:0]            col_index_i,
  input  logic signed [mvm_pkg::DATA_W-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mvm_pkg::IDX_W-1:0]            result_row_o,
  output logic signed [mvm_pkg::DATA_W-1:0]    result_value_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mvm_pkg::CNT_W-1:0]            cfg_data_i
);

  mvm_pkg::cmd_t  cmd;
  mvm_pkg::stat_t stat;

  // sequencer: accepts words, walks rows and columns
  mvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // stores, multiply-accumulate, saturation, output register
  mvm_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_row_o   (result_row_o),
    .result_value_o (result_value_o),
    .last_o         (last_o)
  );

endmodule
